>>> design/rhm_pkg.sv
`timescale 1ns / 1ps

package rhm_pkg;

    // table geometry
    localparam int HIT_CAPACITY = 64;
    localparam int SLOT_W       = $clog2(HIT_CAPACITY);
    localparam int CNT_W        = $clog2(HIT_CAPACITY + 1);

    localparam int POS_W    = 16;
    localparam int EDEP_W   = 20;
    localparam int ENERGY_W = 24;
    localparam int RADIUS_W = 16;
    localparam int R2_W     = 2 * RADIUS_W;
    localparam int SQ_W     = 2 * POS_W;

    // commands carried on s_tuser
    typedef enum logic [1:0] {
        CMD_DEPOSIT  = 2'd0,
        CMD_CLEAR    = 2'd1,
        CMD_READ     = 2'd2,
        CMD_RESERVED = 2'd3
    } cmd_t;

    // result codes carried on m_tuser
    typedef enum logic [2:0] {
        STAT_MERGED   = 3'd0,
        STAT_CREATED  = 3'd1,
        STAT_IGNORED  = 3'd2,
        STAT_DROPPED  = 3'd3,
        STAT_CLEARED  = 3'd4,
        STAT_READ_OK  = 3'd5,
        STAT_READ_BAD = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_RESP
    } state_t;

    // one stored hit
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [ENERGY_W-1:0]     energy;
    } entry_t;

    // distance pipeline result toward the sequencer
    typedef struct packed {
        logic              busy;
        logic              valid;
        logic              hit;
        logic [SLOT_W-1:0] idx;
        entry_t            entry;
    } dist_res_t;

endpackage

>>> design/rhm_hit_mem.sv
`timescale 1ns / 1ps

module rhm_hit_mem (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [rhm_pkg::SLOT_W-1:0] wr_addr,
    input  rhm_pkg::entry_t           wr_data,
    input  logic                      rd_en,
    input  logic [rhm_pkg::SLOT_W-1:0] rd_addr,
    output rhm_pkg::entry_t           rd_data
);
    import rhm_pkg::*;

    entry_t hit_mem_reg [HIT_CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hit_mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= hit_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/rhm_dist_unit.sv
`timescale 1ns / 1ps

module rhm_dist_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             flush,
    input  logic                             in_valid,
    input  logic [rhm_pkg::SLOT_W-1:0]       in_idx,
    input  rhm_pkg::entry_t                  in_entry,
    input  logic signed [rhm_pkg::POS_W-1:0] step_x,
    input  logic signed [rhm_pkg::POS_W-1:0] step_y,
    input  logic signed [rhm_pkg::POS_W-1:0] step_z,
    input  logic [rhm_pkg::R2_W-1:0]         r2,
    output rhm_pkg::dist_res_t               res
);
    import rhm_pkg::*;

    // |a - b| of two signed coordinates, always fits POS_W unsigned bits
    function automatic logic [POS_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                  input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        logic signed [POS_W:0] nd;
        d  = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
        nd = -d;
        return d[POS_W] ? nd[POS_W-1:0] : d[POS_W-1:0];
    endfunction

    // stage a: absolute differences
    logic              va_reg;
    logic [SLOT_W-1:0] idx_a_reg;
    entry_t            ent_a_reg;
    logic [POS_W-1:0]  ax_reg, ay_reg, az_reg;
    // stage b: squares
    logic              vb_reg;
    logic [SLOT_W-1:0] idx_b_reg;
    entry_t            ent_b_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg, sqz_reg;
    // stage c: partial sum
    logic              vc_reg;
    logic [SLOT_W-1:0] idx_c_reg;
    entry_t            ent_c_reg;
    logic [SQ_W:0]     sxy_reg;
    logic [SQ_W-1:0]   sqz_c_reg;
    // stage d: full sum and compare
    logic              vd_reg;
    logic              hit_d_reg;
    logic [SLOT_W-1:0] idx_d_reg;
    entry_t            ent_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        idx_a_reg <= in_idx;
        ent_a_reg <= in_entry;
        ax_reg    <= abs_diff(in_entry.x, step_x);
        ay_reg    <= abs_diff(in_entry.y, step_y);
        az_reg    <= abs_diff(in_entry.z, step_z);

        idx_b_reg <= idx_a_reg;
        ent_b_reg <= ent_a_reg;
        sqx_reg   <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
        sqy_reg   <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        sqz_reg   <= SQ_W'(az_reg) * SQ_W'(az_reg);

        idx_c_reg <= idx_b_reg;
        ent_c_reg <= ent_b_reg;
        sxy_reg   <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        sqz_c_reg <= sqz_reg;

        idx_d_reg <= idx_c_reg;
        ent_d_reg <= ent_c_reg;
        hit_d_reg <= ({1'b0, sxy_reg} + {2'b00, sqz_c_reg}) <= {2'b00, r2};
    end

    assign res.busy  = va_reg | vb_reg | vc_reg | vd_reg;
    assign res.valid = vd_reg;
    assign res.hit   = hit_d_reg;
    assign res.idx   = idx_d_reg;
    assign res.entry = ent_d_reg;

endmodule

>>> design/radius_hit_merge_table.sv
`timescale 1ns / 1ps

// Hit merge table: keeps up to 64 hits per event (position in mm, summed energy
// in keV). A deposit request walks the stored hits in table order, one entry per
// clock through a four-stage squared-distance pipeline behind a dual-port hit
// memory, and merges into the first hit within merge_radius_mm (energy
// saturates at 24 bits); with no match it appends a new hit, or reports
// dropped when the table is full. A deposit's scan time grows with the number
// of stored hits, set by the memory read port and the pipeline depth; a merge
// ends as soon as the matching entry leaves the pipeline. Clear and ignored
// requests go straight to the response state, while reads first pass the read
// state for the memory read; the next request is taken in the cycle after a
// result is loaded. One request is in flight at a time: s_tready is high only
// while the sequencer is idle, and a finished result waits in the m_ output
// register until taken. merge_radius_mm sits at byte address 0 of the APB port
// and must only be written while no request is in flight.
module radius_hit_merge_table (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // deposit_energy[19:0], step_x[35:20], step_y[51:36], step_z[67:52],
    // read_slot[73:68], zero pad[79:74]
    input  logic [79:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // slot[5:0], sum_energy[29:6], slot_x[45:30], slot_y[61:46], slot_z[77:62],
    // count[84:78], zero pad[87:85]
    output logic [87:0] m_tdata,
    // status[2:0]
    output logic [2:0]  m_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rhm_pkg::*;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(50);
    localparam logic [CNT_W-1:0]    CAP_CNT      = CNT_W'(HIT_CAPACITY);

    // request fields
    cmd_t                    in_cmd;
    logic [EDEP_W-1:0]       in_edep;
    logic signed [POS_W-1:0] in_x, in_y, in_z;
    logic [SLOT_W-1:0]       in_rs;

    assign in_cmd  = cmd_t'(s_tuser);
    assign in_edep = s_tdata[19:0];
    assign in_x    = s_tdata[35:20];
    assign in_y    = s_tdata[51:36];
    assign in_z    = s_tdata[67:52];
    assign in_rs   = s_tdata[73:68];

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  issue_reg;
    logic              rd_pending_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [R2_W-1:0]   r2_reg;

    // latched request
    logic [EDEP_W-1:0]       edep_reg;
    logic signed [POS_W-1:0] x_reg, y_reg, z_reg;
    logic [SLOT_W-1:0]       rs_reg;

    // pending result
    status_t                 res_status_reg;
    logic [SLOT_W-1:0]       res_slot_reg;
    logic [ENERGY_W-1:0]     res_energy_reg;
    logic signed [POS_W-1:0] res_x_reg, res_y_reg, res_z_reg;

    // output register
    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;
    status_t     m_tuser_reg;

    // memory and distance pipeline
    logic              mem_wr_en, mem_rd_en;
    logic [SLOT_W-1:0] mem_wr_addr, mem_rd_addr;
    entry_t            mem_wr_data, mem_rd_data;
    dist_res_t         dres;

    // sequencer events
    logic accept, scan_issue, hit_take, scan_end, resp_load, out_free, flush;
    logic table_full, read_in_range;

    // merged energy, saturating
    logic [ENERGY_W:0]   merge_sum;
    logic [ENERGY_W-1:0] merge_sat;

    assign merge_sum = {1'b0, dres.entry.energy} + (ENERGY_W + 1)'(edep_reg);
    assign merge_sat = merge_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : merge_sum[ENERGY_W-1:0];

    assign out_free      = !m_tvalid_reg || m_tready;
    assign table_full    = count_reg >= CAP_CNT;
    assign read_in_range = CNT_W'(rs_reg) < count_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_cmd == CMD_READ) begin
                        state_next = ST_READ;
                    end else if (in_cmd == CMD_DEPOSIT && in_edep != '0) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_READ: state_next = ST_RESP;
            ST_SCAN: begin
                if (hit_take || scan_end) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready    = 1'b0;
        scan_issue  = 1'b0;
        hit_take    = 1'b0;
        scan_end    = 1'b0;
        resp_load   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = issue_reg[SLOT_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                mem_rd_en   = s_tvalid && in_cmd == CMD_READ;
                mem_rd_addr = in_rs;
            end
            ST_READ: ;
            ST_SCAN: begin
                hit_take   = dres.valid && dres.hit;
                // keep issuing until the first match shows up at the pipeline end or every stored hit is issued
                scan_issue = !hit_take && issue_reg < count_reg;
                mem_rd_en  = scan_issue;
                scan_end   = !hit_take && issue_reg >= count_reg &&
                             !rd_pending_reg && !dres.busy;
            end
            ST_RESP: resp_load = out_free;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;
    assign flush  = hit_take;

    // table write: energy update on a merge, new entry on an append
    assign mem_wr_en   = hit_take || (scan_end && !table_full);
    assign mem_wr_addr = hit_take ? dres.idx : count_reg[SLOT_W-1:0];
    always_comb begin
        if (hit_take) begin
            mem_wr_data        = dres.entry;
            mem_wr_data.energy = merge_sat;
        end else begin
            mem_wr_data.x      = x_reg;
            mem_wr_data.y      = y_reg;
            mem_wr_data.z      = z_reg;
            mem_wr_data.energy = ENERGY_W'(edep_reg);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            issue_reg      <= '0;
            rd_pending_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            radius_reg     <= RADIUS_RESET;
        end else begin
            state_reg      <= state_next;
            rd_pending_reg <= scan_issue;
            if (accept) begin
                issue_reg <= '0;
                if (in_cmd == CMD_CLEAR) begin
                    count_reg <= '0;
                end
            end else if (scan_issue) begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (scan_end && !table_full) begin
                count_reg <= count_reg + 1'b1;
            end
            if (resp_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
                radius_reg <= pwdata[RADIUS_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg <= issue_reg[SLOT_W-1:0];
        if (accept) begin
            edep_reg       <= in_edep;
            x_reg          <= in_x;
            y_reg          <= in_y;
            z_reg          <= in_z;
            rs_reg         <= in_rs;
            r2_reg         <= R2_W'(radius_reg) * R2_W'(radius_reg);
            // clear and ignored requests finish here with all-zero slot, energy and position fields
            res_status_reg <= (in_cmd == CMD_CLEAR) ? STAT_CLEARED : STAT_IGNORED;
            res_slot_reg   <= '0;
            res_energy_reg <= '0;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            res_z_reg      <= '0;
        end
        if (state_reg == ST_READ) begin
            res_slot_reg <= rs_reg;
            if (read_in_range) begin
                res_status_reg <= STAT_READ_OK;
                res_energy_reg <= mem_rd_data.energy;
                res_x_reg      <= mem_rd_data.x;
                res_y_reg      <= mem_rd_data.y;
                res_z_reg      <= mem_rd_data.z;
            end else begin
                res_status_reg <= STAT_READ_BAD;
            end
        end
        if (hit_take) begin
            res_status_reg <= STAT_MERGED;
            res_slot_reg   <= dres.idx;
            res_energy_reg <= merge_sat;
            res_x_reg      <= dres.entry.x;
            res_y_reg      <= dres.entry.y;
            res_z_reg      <= dres.entry.z;
        end else if (scan_end) begin
            if (table_full) begin
                res_status_reg <= STAT_DROPPED;
            end else begin
                res_status_reg <= STAT_CREATED;
                res_slot_reg   <= count_reg[SLOT_W-1:0];
                res_energy_reg <= ENERGY_W'(edep_reg);
                res_x_reg      <= x_reg;
                res_y_reg      <= y_reg;
                res_z_reg      <= z_reg;
            end
        end
        if (resp_load) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {3'b000, count_reg, res_z_reg, res_y_reg, res_x_reg,
                            res_energy_reg, res_slot_reg};
        end
    end

    rhm_hit_mem u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rhm_dist_unit u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .flush    (flush),
        .in_valid (rd_pending_reg && !flush),
        .in_idx   (rd_idx_reg),
        .in_entry (mem_rd_data),
        .step_x   (x_reg),
        .step_y   (y_reg),
        .step_z   (z_reg),
        .r2       (r2_reg),
        .res      (dres)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // apb: single register, always ready
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - RADIUS_W){1'b0}}, radius_reg} : 32'd0;

endmodule

>>> design/rhm_checker.sv
`timescale 1ns / 1ps

module rhm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import rhm_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request in flight: no accept right after an accept
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // count never exceeds capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[84:78] <= 7'(HIT_CAPACITY))
        else $error("count above capacity");

    // a clear reports an empty table
    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_CLEARED |-> m_tdata[84:78] == 7'd0)
        else $error("clear with nonzero count");

    // a new hit is always the last entry
    a_create_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_CREATED |-> {1'b0, m_tdata[5:0]} + 7'd1 == m_tdata[84:78])
        else $error("created slot is not the last entry");

endmodule

bind radius_hit_merge_table rhm_checker u_rhm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
